@@ src/can_signal_extractor_macros.svh @@
// ----------------------------------------------------------------------------
// CAN signal extractor assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_EXTRACTOR_MACROS_SVH
`define CAN_SIGNAL_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define CSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN signal extractor package
// Widths, codes, shared types and helper functions for the extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

  // Payload size and field widths
  localparam int PAYLOAD_BYTES = 8;
  localparam int ID_W          = 29;
  localparam int LEN_W         = 4;
  localparam int DATA_W        = 64;
  localparam int OFS_W         = 6;
  localparam int BITS_W        = 7;
  localparam int CNT_W         = 7;
  localparam int TYPE_W        = 3;
  localparam int STAT_W        = 2;
  localparam int IDX_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  // Bit position reaches offset + 64 * 64 after the final step, so 13 bits
  localparam int POS_W         = 13;
  localparam int MAX_ELEMS     = 64;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LEN_ERR   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_OFS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_CNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_TYPE = 3'd5;

  // Field type needing sign extension, and the default raw type
  localparam logic [TYPE_W-1:0] TYPE_SIGNED   = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_UNSIGNED = 3'd2;

  // Low n bits set; saturates at the full word
  function automatic logic [DATA_W-1:0] low_mask(input logic [BITS_W-1:0] n);
    logic [DATA_W-1:0] m;
    if (n >= BITS_W'(DATA_W)) begin
      m = '1;
    end else begin
      m = (DATA_W'(1) << n) - DATA_W'(1);
    end
    return m;
  endfunction

  localparam logic [DATA_W-1:0] PAYLOAD_MASK = low_mask(BITS_W'(PAYLOAD_BYTES * 8));

  // Configuration register set
  typedef struct packed {
    logic [ID_W-1:0]   match_id;
    logic [LEN_W-1:0]  expected_length;
    logic [OFS_W-1:0]  field_offset;
    logic [BITS_W-1:0] field_bits;
    logic [CNT_W-1:0]  field_count;
    logic [TYPE_W-1:0] field_type;
  } cfg_t;

  // Classified frame handed from front to back
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
  } job_t;

endpackage

`default_nettype wire

@@ src/cse_front.sv @@
// ----------------------------------------------------------------------------
// CAN signal extractor front end
// Accepts frames, checks identifier and length, and registers a job.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cse_pkg::cfg_t              cfg,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [cse_pkg::ID_W-1:0]   frame_id,
  input  wire logic [cse_pkg::LEN_W-1:0]  frame_length,
  input  wire logic [cse_pkg::DATA_W-1:0] payload,
  output logic                            job_valid,
  input  wire logic                       job_ready,
  output cse_pkg::job_t                   job
);

  logic                        drop;
  logic [cse_pkg::STAT_W-1:0]  cls_status;

  // Stage is free when empty or when its job moves on this cycle
  assign in_ready = !job_valid || job_ready;

  // Classification: identifier first, then length
  always_comb begin
    drop = 1'b0;
    if (frame_id != cfg.match_id) begin
      cls_status = cse_pkg::STAT_NOT_FOUND;
    end else if (frame_length != cfg.expected_length) begin
      cls_status = cse_pkg::STAT_LEN_ERR;
    end else begin
      cls_status = cse_pkg::STAT_OK;
      // no elements at all: frame yields nothing
      drop = (cfg.field_count == '0);
    end
  end

  // Job register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid && !drop;
    end
    if (in_valid && in_ready) begin
      job.status <= cls_status;
      job.data   <= payload & cse_pkg::PAYLOAD_MASK;
    end
  end

endmodule

`default_nettype wire

@@ src/cse_queue.sv @@
// ----------------------------------------------------------------------------
// CAN signal extractor job queue
// Small register FIFO decoupling classification from extraction.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire cse_pkg::job_t push_job,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output cse_pkg::job_t      pop_job
);

  cse_pkg::job_t                slots [cse_pkg::QDEPTH];
  logic [cse_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cse_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cse_pkg::QCNT_W-1:0]   fill;
  logic                         push;
  logic                         pop;

  assign push_ready = (fill != cse_pkg::QCNT_W'(cse_pkg::QDEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  // Pointer wrap at the queue depth
  function automatic logic [cse_pkg::QPTR_W-1:0] ptr_inc(
    input logic [cse_pkg::QPTR_W-1:0] p
  );
    logic [cse_pkg::QPTR_W-1:0] r;
    if (p == cse_pkg::QPTR_W'(cse_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + cse_pkg::QPTR_W'(1);
    end
    return r;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + cse_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - cse_pkg::QCNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ src/cse_back.sv @@
// ----------------------------------------------------------------------------
// CAN signal extractor back end
// Walks the field array into an output register, one element per cycle while the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cse_pkg::cfg_t               cfg,
  input  wire logic                        pop_valid,
  output logic                             pop_ready,
  input  wire cse_pkg::job_t               pop_job,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cse_pkg::STAT_W-1:0]       status,
  output logic [cse_pkg::IDX_W-1:0]        element_index,
  output logic [cse_pkg::DATA_W-1:0]       value,
  output logic                             last
);

  logic                         busy;
  logic [cse_pkg::STAT_W-1:0]   cur_status;
  logic [cse_pkg::DATA_W-1:0]   cur_data;
  logic [cse_pkg::IDX_W-1:0]    idx;
  logic [cse_pkg::POS_W-1:0]    pos;

  logic [cse_pkg::BITS_W-1:0]   bits_sat;
  logic [cse_pkg::CNT_W-1:0]    count_sat;
  logic [cse_pkg::DATA_W-1:0]   mask;
  logic [cse_pkg::DATA_W-1:0]   shifted;
  logic [cse_pkg::DATA_W-1:0]   elem;
  logic [cse_pkg::DATA_W-1:0]   res_value;
  logic [cse_pkg::IDX_W-1:0]    res_index;
  logic                         is_err;
  logic                         cur_last;
  logic                         emit;
  logic                         pop;

  // Saturated width and count
  assign bits_sat  = (cfg.field_bits > cse_pkg::BITS_W'(cse_pkg::DATA_W)) ?
                     cse_pkg::BITS_W'(cse_pkg::DATA_W) : cfg.field_bits;
  assign count_sat = (cfg.field_count > cse_pkg::CNT_W'(cse_pkg::MAX_ELEMS)) ?
                     cse_pkg::CNT_W'(cse_pkg::MAX_ELEMS) : cfg.field_count;
  assign mask      = cse_pkg::low_mask(bits_sat);

  // Handshake between queue, walker and output register
  assign is_err    = (cur_status != cse_pkg::STAT_OK);
  assign cur_last  = is_err ||
                     ((cse_pkg::CNT_W'(idx) + cse_pkg::CNT_W'(1)) == count_sat);
  assign emit      = busy && (!out_valid || out_ready);
  assign pop_ready = !busy || (emit && cur_last);
  assign pop       = pop_valid && pop_ready;

  // Element extraction and sign extension
  assign shifted = cur_data >> pos[cse_pkg::OFS_W-1:0];
  always_comb begin
    if (pos[cse_pkg::POS_W-1:cse_pkg::OFS_W] == '0) begin
      elem = shifted & mask;
    end else begin
      elem = '0;
    end
    if (cfg.field_type == cse_pkg::TYPE_SIGNED && bits_sat != '0 &&
        bits_sat < cse_pkg::BITS_W'(cse_pkg::DATA_W) &&
        elem[bits_sat[cse_pkg::OFS_W-1:0] - cse_pkg::OFS_W'(1)]) begin
      elem = elem | ~mask;
    end
    // error results carry zero index and value
    if (is_err) begin
      res_value = '0;
      res_index = '0;
    end else begin
      res_value = elem;
      res_index = idx;
    end
  end

  // Walker state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // a new job takes over as the previous one finishes
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && cur_last) begin
        busy <= 1'b0;
      end
    end
    if (emit) begin
      status        <= cur_status;
      element_index <= res_index;
      value         <= res_value;
      last          <= cur_last;
    end
    if (pop) begin
      cur_status <= pop_job.status;
      cur_data   <= pop_job.data;
      idx        <= '0;
      pos        <= cse_pkg::POS_W'(cfg.field_offset);
    end else if (emit) begin
      idx        <= idx + cse_pkg::IDX_W'(1);
      pos        <= pos + cse_pkg::POS_W'(bits_sat);
    end
  end

endmodule

`default_nettype wire

@@ src/can_signal_extractor.sv @@
// ----------------------------------------------------------------------------
// CAN signal extractor
// Decodes one array signal from a little-endian CAN frame payload.
// ----------------------------------------------------------------------------
// A frame is taken whenever the front stage or the two-entry job queue has
// room; the back end then gives one result per cycle while the output is
// taken: one result for a frame whose identifier or length is wrong,
// field_count results (saturated at 64) for a matching frame, none when
// field_count is zero. A matching frame thus occupies the back end while its
// single element counter and shifter walk its field_count elements; results
// of one frame are followed without a gap by those of the next when it is
// already queued. Registers are written through the configuration channel,
// which is always ready; writes to unused indexes are ignored.
`default_nettype none

module can_signal_extractor (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cse_pkg::CFG_DATA_W-1:0] cfg_data,
  // frame input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cse_pkg::ID_W-1:0]       frame_id,
  input  wire logic [cse_pkg::LEN_W-1:0]      frame_length,
  input  wire logic [cse_pkg::DATA_W-1:0]     payload,
  // result output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cse_pkg::STAT_W-1:0]          status,
  output logic [cse_pkg::IDX_W-1:0]           element_index,
  output logic [cse_pkg::DATA_W-1:0]          value,
  output logic                                last
);

  cse_pkg::cfg_t cfg;
  cse_pkg::job_t front_job;
  cse_pkg::job_t queue_job;
  logic          front_valid;
  logic          front_ready;
  logic          queue_valid;
  logic          queue_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_id        <= '0;
      cfg.expected_length <= cse_pkg::LEN_W'(8);
      cfg.field_offset    <= '0;
      cfg.field_bits      <= cse_pkg::BITS_W'(8);
      cfg.field_count     <= cse_pkg::CNT_W'(1);
      cfg.field_type      <= cse_pkg::TYPE_UNSIGNED;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cse_pkg::REG_MATCH_ID:   cfg.match_id        <= cfg_data[cse_pkg::ID_W-1:0];
        cse_pkg::REG_EXP_LENGTH: cfg.expected_length <= cfg_data[cse_pkg::LEN_W-1:0];
        cse_pkg::REG_FIELD_OFS:  cfg.field_offset    <= cfg_data[cse_pkg::OFS_W-1:0];
        cse_pkg::REG_FIELD_BITS: cfg.field_bits      <= cfg_data[cse_pkg::BITS_W-1:0];
        cse_pkg::REG_FIELD_CNT:  cfg.field_count     <= cfg_data[cse_pkg::CNT_W-1:0];
        cse_pkg::REG_FIELD_TYPE: cfg.field_type      <= cfg_data[cse_pkg::TYPE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Classification front end
  cse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .frame_id     (frame_id),
    .frame_length (frame_length),
    .payload      (payload),
    .job_valid    (front_valid),
    .job_ready    (front_ready),
    .job          (front_job)
  );

  // Job queue
  cse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_job    (queue_job)
  );

  // Extraction back end
  cse_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .pop_valid     (queue_valid),
    .pop_ready     (queue_ready),
    .pop_job       (queue_job),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .element_index (element_index),
    .value         (value),
    .last          (last)
  );

endmodule

`default_nettype wire

@@ src/cse_checker.sv @@
// ----------------------------------------------------------------------------
// CAN signal extractor checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_signal_extractor_macros.svh"

module cse_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [cse_pkg::STAT_W-1:0] status,
  input  wire logic [cse_pkg::IDX_W-1:0]  element_index,
  input  wire logic [cse_pkg::DATA_W-1:0] value,
  input  wire logic                       last
);

  // A stalled result holds
  `CSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(element_index) && $stable(last), "stalled result changed")

  // Error results stand alone with zero index and value
  `CSE_ASSERT_SAME(a_err_shape, out_valid && status != cse_pkg::STAT_OK, last && element_index == '0 && value == '0, "malformed error result")

  // Only defined status codes appear
  `CSE_ASSERT_SAME(a_status_code, out_valid, status == cse_pkg::STAT_OK || status == cse_pkg::STAT_NOT_FOUND || status == cse_pkg::STAT_LEN_ERR, "undefined status code")

  // Within a frame the element index steps by one
  `CSE_ASSERT_NEXT(a_index_step, out_valid && out_ready && status == cse_pkg::STAT_OK && !last, !out_valid || (status == cse_pkg::STAT_OK && element_index == $past(element_index) + cse_pkg::IDX_W'(1)), "element index skipped")

endmodule

bind can_signal_extractor cse_checker u_cse_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .status        (status),
  .element_index (element_index),
  .value         (value),
  .last          (last)
);

`default_nettype wire
